FILE: design/cse_pkg.sv
// Package for the CAN signal extractor: shared types, register indexes
// and constants. No dependencies.
package cse_pkg;

  localparam int unsigned IdW     = 11;
  localparam int unsigned LenW    = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SpeedW  = 15;
  localparam int unsigned RawW    = 12;
  localparam int unsigned BandW   = 10;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Input commands
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SPEED_ID = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MODE_ID  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEADBAND = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_WINDOW   = 2'd3;

  // Reset values of the registers
  localparam logic [BandW-1:0]  DEADBAND_RST = 10'd30;
  localparam logic [CountW-1:0] WINDOW_RST   = 16'd1000;

  // Speed scaling: raw * 8 - 4000, in 0.01 km/h
  localparam int unsigned      SpeedShift   = 3;
  localparam logic [SpeedW-1:0] SPEED_OFFSET = 15'd4000;
  localparam logic [LenW-1:0]   MIN_LEN      = 4'd3;
  localparam logic [CountW-1:0] COUNT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic              command;
    logic [IdW-1:0]    frame_id;
    logic [LenW-1:0]   data_length;
    logic [ByteW-1:0]  data_byte_zero;
    logic [ByteW-1:0]  data_byte_one;
    logic [ByteW-1:0]  data_byte_two;
  } item_t;

  typedef struct packed {
    logic [IdW-1:0]    speed_frame_id;
    logic [IdW-1:0]    mode_frame_id;
    logic [BandW-1:0]  speed_deadband;
    logic [CountW-1:0] rate_window_ms;
  } cfg_t;

  typedef struct packed {
    logic              speed_changed;
    logic [SpeedW-1:0] speed_centi_kmh;
    logic              mode_changed;
    logic [ModeW-1:0]  drive_mode;
    logic              rate_updated;
    logic [CountW-1:0] frame_rate;
  } result_t;

endpackage

FILE: design/cse_speed_dec.sv
// Speed field decode and deadband compare for the CAN signal extractor.
// Depends on cse_pkg.
module cse_speed_dec
  import cse_pkg::*;
(
  input  logic [LenW-1:0]   data_length,
  input  logic [ByteW-1:0]  data_byte_one,
  input  logic [ByteW-1:0]  data_byte_two,
  input  logic [SpeedW-1:0] stored_speed,
  input  logic [BandW-1:0]  deadband,
  output logic [SpeedW-1:0] new_speed,
  output logic              beyond_band
);

  logic [RawW-1:0]   raw;
  logic [SpeedW-1:0] scaled;
  logic [SpeedW-1:0] diff;

  always_comb begin
    raw    = {data_byte_two, data_byte_one[ByteW-1:ByteW/2]};
    scaled = {raw, {SpeedShift{1'b0}}};
    // clamp at zero; short frames read as standstill
    if (data_length < MIN_LEN || scaled <= SPEED_OFFSET) begin
      new_speed = '0;
    end else begin
      new_speed = scaled - SPEED_OFFSET;
    end
    diff = (new_speed > stored_speed) ? new_speed - stored_speed
                                      : stored_speed - new_speed;
    beyond_band = diff > {{(SpeedW-BandW){1'b0}}, deadband};
  end

endmodule

FILE: design/cse_state.sv
// Tracked state of the CAN signal extractor: speed, mode, frame counter,
// window timer, published rate; forms each result. Needs cse_pkg, cse_speed_dec.
module cse_state
  import cse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [SpeedW-1:0] speed_r, speed_nxt;
  logic [ModeW-1:0]  mode_r, mode_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] elapsed_r, elapsed_nxt;
  logic [CountW-1:0] rate_r, rate_nxt;

  logic [SpeedW-1:0] dec_speed;
  logic              dec_beyond;
  logic [CountW-1:0] count_inc;
  logic [ModeW-1:0]  frame_mode;
  logic              speed_chg, mode_chg, rate_upd;

  cse_speed_dec u_speed_dec (
    .data_length   (item.data_length),
    .data_byte_one (item.data_byte_one),
    .data_byte_two (item.data_byte_two),
    .stored_speed  (speed_r),
    .deadband      (cfg.speed_deadband),
    .new_speed     (dec_speed),
    .beyond_band   (dec_beyond)
  );

  always_comb begin
    speed_nxt   = speed_r;
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    rate_nxt    = rate_r;
    speed_chg   = 1'b0;
    mode_chg    = 1'b0;
    rate_upd    = 1'b0;
    frame_mode  = item.data_byte_zero[ModeW-1:0];
    count_inc   = (count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;

    if (item.command == CMD_TICK) begin
      if (elapsed_r != COUNT_MAX) elapsed_nxt = elapsed_r + 1'b1;
    end else begin
      count_nxt = count_inc;
      if (elapsed_r >= cfg.rate_window_ms) begin
        rate_nxt    = count_inc;
        count_nxt   = '0;
        elapsed_nxt = '0;
        rate_upd    = 1'b1;
      end
      if (item.frame_id == cfg.speed_frame_id && dec_beyond) begin
        speed_nxt = dec_speed;
        speed_chg = 1'b1;
      end
      if (cfg.mode_frame_id != '0 && item.frame_id == cfg.mode_frame_id &&
          frame_mode != mode_r) begin
        mode_nxt = frame_mode;
        mode_chg = 1'b1;
      end
    end

    result.speed_changed   = speed_chg;
    result.speed_centi_kmh = speed_nxt;
    result.mode_changed    = mode_chg;
    result.drive_mode      = mode_nxt;
    result.rate_updated    = rate_upd;
    result.frame_rate      = rate_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= '0;
      mode_r    <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
      rate_r    <= '0;
    end else if (adv) begin
      speed_r   <= speed_nxt;
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      rate_r    <= rate_nxt;
    end
  end

endmodule

FILE: design/can_signal_extractor_with_deadband.sv
// CAN signal extractor top level: input register, state update, result register.
// The result is registered: an item passes the input register, then the result
// register; one item per cycle while out_ready does not stall the result side.
// Throughput is set by the single state update between the two registers.
// Reset (rst_n low, synchronous) empties both registers and restores defaults.
// Depends on cse_pkg, cse_state and cse_speed_dec.
module can_signal_extractor_with_deadband
  import cse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_wdata,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [IdW-1:0]      in_frame_id,
  input  logic [LenW-1:0]     in_data_length,
  input  logic [ByteW-1:0]    in_data_byte_zero,
  input  logic [ByteW-1:0]    in_data_byte_one,
  input  logic [ByteW-1:0]    in_data_byte_two,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_speed_changed,
  output logic [SpeedW-1:0]   out_speed_centi_kmh,
  output logic                out_mode_changed,
  output logic [ModeW-1:0]    out_drive_mode,
  output logic                out_rate_updated,
  output logic [CountW-1:0]   out_frame_rate
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    in_valid_r;
  result_t res_r;
  logic    out_valid_r;
  result_t res_nxt;
  logic    adv;
  logic    in_xfer;

  // Advance the held item when the result register is empty or being drained
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;
  assign in_xfer  = in_valid && in_ready;

  // Config registers; the user writes only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_frame_id <= '0;
      cfg_r.mode_frame_id  <= '0;
      cfg_r.speed_deadband <= DEADBAND_RST;
      cfg_r.rate_window_ms <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_ID: cfg_r.speed_frame_id <= cfg_wdata[IdW-1:0];
        REG_MODE_ID:  cfg_r.mode_frame_id  <= cfg_wdata[IdW-1:0];
        REG_DEADBAND: cfg_r.speed_deadband <= cfg_wdata[BandW-1:0];
        REG_WINDOW:   cfg_r.rate_window_ms <= cfg_wdata[CountW-1:0];
        default:      ;
      endcase
    end
  end

  // Input register: take a transfer whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_xfer || (in_valid_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.command        <= in_command;
      item_r.frame_id       <= in_frame_id;
      item_r.data_length    <= in_data_length;
      item_r.data_byte_zero <= in_data_byte_zero;
      item_r.data_byte_one  <= in_data_byte_one;
      item_r.data_byte_two  <= in_data_byte_two;
    end
  end

  // State update and result forming; state commits only on advance
  cse_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (res_nxt)
  );

  // Result register: hold until the downstream side takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= adv || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_speed_changed   = res_r.speed_changed;
  assign out_speed_centi_kmh = res_r.speed_centi_kmh;
  assign out_mode_changed    = res_r.mode_changed;
  assign out_drive_mode      = res_r.drive_mode;
  assign out_rate_updated    = res_r.rate_updated;
  assign out_frame_rate      = res_r.frame_rate;

endmodule

FILE: design/cse_checker.sv
// Port-level checks for the CAN signal extractor, bound to the top level.
// Depends on cse_pkg.
module cse_checker
  import cse_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_mode_changed,
  input logic [ModeW-1:0]  out_drive_mode,
  input logic              out_rate_updated,
  input logic [CountW-1:0] out_frame_rate
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_mode) &&
    $stable(out_frame_rate))
    else $error("stalled result changed");

  // Without a publication, the rate carries over between consecutive results
  a_rate_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) ##1 (out_valid && !out_rate_updated) |->
    out_frame_rate == $past(out_frame_rate))
    else $error("frame rate changed without publication");

  // Without a mode report, the mode carries over
  a_mode_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) ##1 (out_valid && !out_mode_changed) |->
    out_drive_mode == $past(out_drive_mode))
    else $error("drive mode changed without report");

  // A mode report always carries a different mode
  a_mode_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) ##1 (out_valid && out_mode_changed) |->
    out_drive_mode != $past(out_drive_mode))
    else $error("mode report without a new mode");

endmodule

bind can_signal_extractor_with_deadband cse_checker u_cse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_mode_changed (out_mode_changed),
  .out_drive_mode   (out_drive_mode),
  .out_rate_updated (out_rate_updated),
  .out_frame_rate   (out_frame_rate)
);

FILE: tb/can_signal_extractor_with_deadband_tb.sv
// Self-checking testbench for the CAN signal extractor with deadband.
// Drives frames and millisecond ticks through valid/ready, predicts every result
// in-line and compares field by field. Depends on cse_pkg and the block's RTL.
module can_signal_extractor_with_deadband_tb;
  import cse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung
  localparam int unsigned StallLimit = 2000;
  // Cycles to hold off after the last result before touching registers or ending
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems = 85;
  localparam int unsigned MaxPrinted = 100;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    item_t              it;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    reg_val;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]     cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = CMD_FRAME;
  logic [IdW-1:0]      in_frame_id = '0;
  logic [LenW-1:0]     in_data_length = '0;
  logic [ByteW-1:0]    in_data_byte_zero = '0;
  logic [ByteW-1:0]    in_data_byte_one = '0;
  logic [ByteW-1:0]    in_data_byte_two = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_speed_changed;
  logic [SpeedW-1:0]   out_speed_centi_kmh;
  logic                out_mode_changed;
  logic [ModeW-1:0]    out_drive_mode;
  logic                out_rate_updated;
  logic [CountW-1:0]   out_frame_rate;

  // Predictor copy of the registers
  logic [IdW-1:0]      cur_speed_id;
  logic [IdW-1:0]      cur_mode_id;
  logic [BandW-1:0]    cur_deadband;
  logic [CountW-1:0]   cur_window;
  // Predictor copy of the block state
  logic [SpeedW-1:0]   held_speed;
  logic [ModeW-1:0]    held_mode;
  logic [CountW-1:0]   frames_seen;
  logic [CountW-1:0]   ms_elapsed;
  logic [CountW-1:0]   last_rate;

  result_t             expected_results[$];
  stim_row_t           directed_rows[$];
  int unsigned         mismatches = 0;
  int unsigned         results_seen = 0;
  int unsigned         quiet_cycles = 0;
  // When set, neither side idles nor stalls
  bit                  flow_steady = 1'b0;

  can_signal_extractor_with_deadband DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_frame_id         (in_frame_id),
    .in_data_length      (in_data_length),
    .in_data_byte_zero   (in_data_byte_zero),
    .in_data_byte_one    (in_data_byte_one),
    .in_data_byte_two    (in_data_byte_two),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_speed_changed   (out_speed_changed),
    .out_speed_centi_kmh (out_speed_centi_kmh),
    .out_mode_changed    (out_mode_changed),
    .out_drive_mode      (out_drive_mode),
    .out_rate_updated    (out_rate_updated),
    .out_frame_rate      (out_frame_rate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MaxPrinted) begin
      $display("%0t result %0d: %s", $time, results_seen, msg);
    end
    mismatches++;
  endtask

  // Advance the predicted state by one item and return the result it causes.
  function automatic result_t extract_signals(item_t it);
    result_t     r;
    int unsigned raw;
    int unsigned spd;
    int unsigned gap;
    r = '0;
    if (it.command == CMD_TICK) begin
      // a tick only ages the window; elapsed time saturates
      if (ms_elapsed != COUNT_MAX) ms_elapsed++;
    end else begin
      // count first, so a publishing frame includes itself
      if (frames_seen != COUNT_MAX) frames_seen++;
      if (ms_elapsed >= cur_window) begin
        last_rate = frames_seen;
        frames_seen = '0;
        ms_elapsed = '0;
        r.rate_updated = 1'b1;
      end
      if (it.frame_id == cur_speed_id) begin
        // raw field is all of byte two above the upper nibble of byte one
        raw = {it.data_byte_two, it.data_byte_one[7:4]};
        spd = raw << SpeedShift;
        // short frames read as standstill; clamp below the offset at zero
        if (it.data_length < MIN_LEN || spd <= SPEED_OFFSET) spd = 0;
        else spd = spd - SPEED_OFFSET;
        gap = (spd > held_speed) ? spd - held_speed : held_speed - spd;
        if (gap > cur_deadband) begin
          held_speed = spd[SpeedW-1:0];
          r.speed_changed = 1'b1;
        end
      end
      // a zero mode identifier disables mode decoding altogether
      if (cur_mode_id != '0 && it.frame_id == cur_mode_id &&
          it.data_byte_zero[ModeW-1:0] != held_mode) begin
        held_mode = it.data_byte_zero[ModeW-1:0];
        r.mode_changed = 1'b1;
      end
    end
    r.speed_centi_kmh = held_speed;
    r.drive_mode = held_mode;
    r.frame_rate = last_rate;
    return r;
  endfunction

  // Random item: mostly frames aimed at the configured identifiers, with a speed
  // close to the held one half the time so the deadband edge is exercised.
  function automatic item_t random_frame();
    item_t it;
    int    pick;
    int    target;
    int    raw;
    pick = int'($urandom_range(99));
    it.command = ($urandom_range(99) < 25) ? CMD_TICK : CMD_FRAME;
    if (pick < 45) it.frame_id = cur_speed_id;
    else if (pick < 75) it.frame_id = cur_mode_id;
    else it.frame_id = IdW'($urandom);
    it.data_length = ($urandom_range(99) < 65) ? 4'd8 : LenW'($urandom_range(15));
    it.data_byte_zero = ByteW'($urandom);
    if ($urandom_range(1) == 1) begin
      target = int'(held_speed) + int'($urandom_range(2 * cur_deadband + 32))
               - int'(cur_deadband) - 16;
      raw = (target + int'(SPEED_OFFSET)) / 8;
      if (raw < 0) raw = 0;
      if (raw > 4095) raw = 4095;
    end else begin
      raw = int'($urandom_range(4095));
    end
    it.data_byte_two = raw[11:4];
    it.data_byte_one = {raw[3:0], 4'($urandom)};
    return it;
  endfunction

  function automatic stim_row_t frame_row(logic [IdW-1:0] id, logic [LenW-1:0] len,
                                          logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    stim_row_t r;
    r = '{kind: ROW_ITEM, it: '0, reg_idx: '0, reg_val: '0, typed: 1'b0, want: '0};
    r.it = '{command: CMD_FRAME, frame_id: id, data_length: len,
             data_byte_zero: b0, data_byte_one: b1, data_byte_two: b2};
    return r;
  endfunction

  function automatic stim_row_t tick_row();
    stim_row_t r;
    // payload is noise; a tick must ignore it
    r = frame_row(IdW'($urandom), LenW'($urandom), ByteW'($urandom),
                  ByteW'($urandom), ByteW'($urandom));
    r.it.command = CMD_TICK;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    stim_row_t r;
    r = frame_row('0, '0, '0, '0, '0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t known(stim_row_t r, logic sc, logic [SpeedW-1:0] sp,
                                      logic mc, logic [ModeW-1:0] md,
                                      logic ru, logic [CountW-1:0] fr);
    r.typed = 1'b1;
    r.want = '{speed_changed: sc, speed_centi_kmh: sp, mode_changed: mc,
               drive_mode: md, rate_updated: ru, frame_rate: fr};
    return r;
  endfunction

  // Present one item and hold it until the transfer. Entered and left just after
  // a rising edge; the expectation is queued at the edge of the transfer.
  task automatic transfer_item(item_t it, bit typed, result_t want);
    int unsigned idle;
    result_t     got;
    idle = 0;
    while (!flow_steady && $urandom_range(99) < 35) idle++;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= it.command;
    in_frame_id       <= it.frame_id;
    in_data_length    <= it.data_length;
    in_data_byte_zero <= it.data_byte_zero;
    in_data_byte_one  <= it.data_byte_one;
    in_data_byte_two  <= it.data_byte_two;
    do @(posedge clk); while (!in_ready);
    got = extract_signals(it);
    expected_results.push_back(typed ? want : got);
  endtask

  // Drop valid and wait until every expected result has arrived, then hold off.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPEED_ID: cur_speed_id = val[IdW-1:0];
      REG_MODE_ID:  cur_mode_id  = val[IdW-1:0];
      REG_DEADBAND: cur_deadband = val[BandW-1:0];
      REG_WINDOW:   cur_window   = val[CountW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Result side: check each transfer against the oldest expectation and
  // stall at random unless the steady stretch is running.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_speed_changed !== want.speed_changed)
          report_mismatch($sformatf("speed_changed got %0b want %0b",
                                    out_speed_changed, want.speed_changed));
        if (out_speed_centi_kmh !== want.speed_centi_kmh)
          report_mismatch($sformatf("speed_centi_kmh got %0d want %0d",
                                    out_speed_centi_kmh, want.speed_centi_kmh));
        if (out_mode_changed !== want.mode_changed)
          report_mismatch($sformatf("mode_changed got %0b want %0b",
                                    out_mode_changed, want.mode_changed));
        if (out_drive_mode !== want.drive_mode)
          report_mismatch($sformatf("drive_mode got %0d want %0d",
                                    out_drive_mode, want.drive_mode));
        if (out_rate_updated !== want.rate_updated)
          report_mismatch($sformatf("rate_updated got %0b want %0b",
                                    out_rate_updated, want.rate_updated));
        if (out_frame_rate !== want.frame_rate)
          report_mismatch($sformatf("frame_rate got %0d want %0d",
                                    out_frame_rate, want.frame_rate));
      end
      results_seen++;
    end
    out_ready <= flow_steady || ($urandom_range(99) >= 35);
  end

  // Watchdog: any transfer on either side, or reset, restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("can_signal_extractor_with_deadband: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    item_t              it;
    logic [IdW-1:0]     sid;
    logic [IdW-1:0]     mid;
    logic [BandW-1:0]   band;
    logic [CountW-1:0]  win;
    int unsigned        pick;

    cur_speed_id = '0;
    cur_mode_id  = '0;
    cur_deadband = DEADBAND_RST;
    cur_window   = WINDOW_RST;
    held_speed   = '0;
    held_mode    = '0;
    frames_seen  = '0;
    ms_elapsed   = '0;
    last_rate    = '0;

    // Directed rows. Defaults apply first: speed id 0, mode decoding off,
    // deadband 30, window 1000.
    directed_rows.push_back(known(tick_row(), 1'b0, '0, 1'b0, '0, 1'b0, '0));
    // full-scale raw field gives the top speed
    directed_rows.push_back(known(frame_row(11'h000, 4'd8, 8'h00, 8'hF0, 8'hFF),
                                  1'b1, 15'd28760, 1'b0, '0, 1'b0, '0));
    // short frame reads as standstill
    directed_rows.push_back(known(frame_row(11'h000, 4'd2, 8'h00, 8'hF0, 8'hFF),
                                  1'b1, '0, 1'b0, '0, 1'b0, '0));
    // mode byte ignored while mode decoding is off; zero speed unchanged
    directed_rows.push_back(known(frame_row(11'h000, 4'd8, 8'hFF, 8'h00, 8'h00),
                                  1'b0, '0, 1'b0, '0, 1'b0, '0));
    // raw exactly at the offset, with a length code above eight
    directed_rows.push_back(frame_row(11'h000, 4'd15, 8'h03, 8'h40, 8'h1F));
    // just past the deadband, then just inside it
    directed_rows.push_back(frame_row(11'h000, 4'd9, 8'h00, 8'h80, 8'h1F));
    directed_rows.push_back(frame_row(11'h000, 4'd8, 8'h00, 8'h7F, 8'h1F));
    directed_rows.push_back(frame_row(11'h7FF, 4'd8, 8'h02, 8'hFF, 8'hFF));
    // both identifiers on one frame, zero deadband, zero window
    directed_rows.push_back(cfg_row(REG_SPEED_ID, 16'h07FF));
    directed_rows.push_back(cfg_row(REG_MODE_ID, 16'h07FF));
    directed_rows.push_back(cfg_row(REG_DEADBAND, 16'd0));
    directed_rows.push_back(cfg_row(REG_WINDOW, 16'd0));
    directed_rows.push_back(frame_row(11'h7FF, 4'd0, 8'hFF, 8'hFF, 8'hFF));
    directed_rows.push_back(frame_row(11'h7FF, 4'd1, 8'h03, 8'h00, 8'h00));
    directed_rows.push_back(tick_row());
    directed_rows.push_back(frame_row(11'h7FF, 4'd3, 8'h01, 8'h00, 8'h00));
    // deadband 1000 and widest window; change of exactly the deadband is not reported
    directed_rows.push_back(cfg_row(REG_SPEED_ID, 16'h0123));
    directed_rows.push_back(cfg_row(REG_MODE_ID, 16'h0001));
    directed_rows.push_back(cfg_row(REG_DEADBAND, 16'd1000));
    directed_rows.push_back(cfg_row(REG_WINDOW, 16'hFFFF));
    directed_rows.push_back(frame_row(11'h123, 4'd3, 8'h00, 8'hF0, 8'hFF));
    directed_rows.push_back(frame_row(11'h001, 4'd1, 8'hFC, 8'h00, 8'h00));
    directed_rows.push_back(frame_row(11'h123, 4'd8, 8'h00, 8'h20, 8'hF8));
    directed_rows.push_back(frame_row(11'h123, 4'd8, 8'h00, 8'h10, 8'hF8));
    directed_rows.push_back(frame_row(11'h000, 4'd8, 8'h02, 8'h55, 8'hAA));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        transfer_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: low extremes, high extremes, then random settings with
    // short windows so the count is published often.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          sid = '0; mid = '0; band = '0; win = 16'd1;
        end
        1: begin
          sid = 11'h7FF; mid = 11'h7FF; band = 10'd1000; win = 16'hFFFF;
        end
        default: begin
          sid = IdW'($urandom_range(2047));
          pick = $urandom_range(99);
          if (pick < 25) mid = '0;
          else if (pick < 50) mid = sid;
          else mid = IdW'($urandom_range(2047));
          band = ($urandom_range(99) < 50) ? BandW'($urandom_range(60))
                                           : BandW'($urandom_range(1000));
          win = CountW'($urandom_range(40, 1));
        end
      endcase
      settle();
      write_reg(REG_SPEED_ID, CfgW'(sid));
      write_reg(REG_MODE_ID, CfgW'(mid));
      write_reg(REG_DEADBAND, CfgW'(band));
      write_reg(REG_WINDOW, win);
      // one phase runs with no idling on either side
      flow_steady = (phase == 3);
      repeat (PhaseItems) begin
        it = random_frame();
        transfer_item(it, 1'b0, '0);
      end
      flow_steady = 1'b0;
    end

    // Drain, then allow a few more cycles for any stray result to show.
    settle();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("can_signal_extractor_with_deadband: match");
    end else begin
      $display("can_signal_extractor_with_deadband: mismatch");
    end
    $finish;
  end

endmodule
